// ----- sv/hpf_pkg.sv -----
package hpf_pkg;

  localparam int MAX_BINS    = 4096;
  localparam int MAX_PEAKS   = 64;
  localparam int WINDOW_HALF = 3;

  localparam int WIN_LEN = 2 * WINDOW_HALF + 1;
  localparam int BIN_AW  = $clog2(MAX_BINS);
  localparam int BIN_CW  = BIN_AW + 1;
  localparam int PK_AW   = $clog2(MAX_PEAKS);
  localparam int PK_CW   = $clog2(MAX_PEAKS + 1);

  localparam int COUNT_W  = 24;
  localparam int BIN_W    = 12;
  localparam int TOTAL_W  = 7;
  localparam int ENT_W    = 32;
  localparam int PM_W     = 10;
  localparam int LIM_W    = 7;
  localparam int PCT_W    = 7;
  localparam int CFG_IW   = 3;
  localparam int CFG_DW   = 32;

  localparam int SCALED_W = COUNT_W + PM_W;
  localparam int THR_W    = PM_W + ENT_W;
  localparam int REJ_W    = COUNT_W + PCT_W;

  localparam logic [PM_W-1:0]  PERMILLE_SCALE = 10'd1000;
  localparam logic [PCT_W-1:0] PERCENT_SCALE  = 7'd100;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_TOTAL_ENTRIES  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_MAJOR_PERMILLE = 3'd1;
  localparam logic [CFG_IW-1:0] REG_MINOR_PERMILLE = 3'd2;
  localparam logic [CFG_IW-1:0] REG_EARLY_LIMIT    = 3'd3;
  localparam logic [CFG_IW-1:0] REG_REJECT_PERCENT = 3'd4;

  localparam logic [ENT_W-1:0] RST_TOTAL_ENTRIES  = '0;
  localparam logic [PM_W-1:0]  RST_MAJOR_PERMILLE = 10'd10;
  localparam logic [PM_W-1:0]  RST_MINOR_PERMILLE = 10'd2;
  localparam logic [LIM_W-1:0] RST_EARLY_LIMIT    = 7'd2;
  localparam logic [PCT_W-1:0] RST_REJECT_PERCENT = 7'd25;

  typedef struct packed {
    logic [COUNT_W-1:0] bin_count;
    logic               last_bin;
  } in_item_t;

  typedef struct packed {
    logic [BIN_W-1:0]   peak_bin;
    logic [COUNT_W-1:0] peak_height;
    logic [TOTAL_W-1:0] peak_total;
    logic               peak_valid;
    logic               last_peak;
  } out_item_t;

  typedef struct packed {
    logic load;      // store one bin
    logic start;     // last bin taken, arm the search
    logic scan_run;  // stream stored bins through the window
    logic drop_eval; // first-peak check
    logic emit_rd;   // read peak list entry
    logic emit_wr;   // load output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic emit_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- sv/histogram_peak_finder.sv -----
// Histogram peak finder. Bin counts arrive one beat per cycle while in_stall is
// low, in ascending bin order, and go to an on-chip bin store; the beat flagged
// last_bin starts the search, and the input stalls until the run's results are
// handed over. The search streams the stored bins once through a sliding window,
// one bin a cycle off the store's read port; the first-peak check follows, then
// each result is read from the peak list and handed out, held by any output
// stall. A run that keeps no peak gives one result with peak_valid low. The user
// must write configuration only between runs; the block does not enforce it.
module histogram_peak_finder import hpf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  hpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  hpf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- sv/hpf_ctrl.sv -----
module hpf_ctrl import hpf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_item_t  in_data,
  output logic      in_stall,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DROP = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       in_beat;

  assign in_stall = (state_r != S_IDLE);
  assign in_beat  = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.load      = in_beat;
    cmd.start     = in_beat && in_data.last_bin;
    cmd.scan_run  = (state_r == S_SCAN);
    cmd.drop_eval = (state_r == S_DROP);
    cmd.emit_rd   = (state_r == S_RD);
    cmd.emit_wr   = (state_r == S_WR) && stat.out_free;
    unique case (state_r)
      S_IDLE: if (cmd.start) state_nxt = S_SCAN;
      S_SCAN: if (stat.scan_done) state_nxt = S_CHK;
      S_CHK:  state_nxt = S_DROP;
      S_DROP: state_nxt = S_RD;
      S_RD:   state_nxt = S_WR;
      S_WR: begin
        if (stat.out_free) state_nxt = stat.emit_last ? S_IDLE : S_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// ----- sv/hpf_dp.sv -----
module hpf_dp import hpf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  in_item_t          in_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  ctrl_cmd_t         cmd,
  output dp_stat_t          stat,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data
);

  // configuration
  logic [ENT_W-1:0] total_r;
  logic [PM_W-1:0]  major_r, minor_r;
  logic [LIM_W-1:0] early_r;
  logic [PCT_W-1:0] reject_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= RST_TOTAL_ENTRIES;
      major_r  <= RST_MAJOR_PERMILLE;
      minor_r  <= RST_MINOR_PERMILLE;
      early_r  <= RST_EARLY_LIMIT;
      reject_r <= RST_REJECT_PERCENT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOTAL_ENTRIES:  total_r  <= cfg_wdata[ENT_W-1:0];
        REG_MAJOR_PERMILLE: major_r  <= cfg_wdata[PM_W-1:0];
        REG_MINOR_PERMILLE: minor_r  <= cfg_wdata[PM_W-1:0];
        REG_EARLY_LIMIT:    early_r  <= cfg_wdata[LIM_W-1:0];
        REG_REJECT_PERCENT: reject_r <= cfg_wdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // thresholds follow the registers, settled long before the first compare
  logic [THR_W-1:0] maj_thr_r, min_thr_r;
  always_ff @(posedge clk) begin
    maj_thr_r <= THR_W'(major_r) * THR_W'(total_r);
    min_thr_r <= THR_W'(minor_r) * THR_W'(total_r);
  end

  // bin store
  logic [COUNT_W-1:0] bin_mem [MAX_BINS];
  logic [BIN_CW-1:0]  wr_idx_r, n_r, rd_ptr_r, shift_cnt_r;
  logic [BIN_CW-1:0]  wr_idx_inc;
  logic               wr_room, rd_issue;
  logic               rd_vld_r;
  logic [COUNT_W-1:0] rd_q_r;

  assign wr_room    = (wr_idx_r < BIN_CW'(MAX_BINS));
  assign wr_idx_inc = wr_room ? wr_idx_r + BIN_CW'(1) : wr_idx_r;
  assign rd_issue   = cmd.scan_run && (rd_ptr_r < n_r);

  always_ff @(posedge clk) begin
    if (cmd.load && wr_room) bin_mem[wr_idx_r[BIN_AW-1:0]] <= in_data.bin_count;
    if (rd_issue) rd_q_r <= bin_mem[rd_ptr_r[BIN_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
    end else if (cmd.start) begin
      wr_idx_r <= '0;
    end else if (cmd.load) begin
      wr_idx_r <= wr_idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) n_r <= wr_idx_inc;
  end

  // window streaming
  logic [COUNT_W-1:0] win_r [WIN_LEN];
  logic               eval_r, skip_r;
  logic [BIN_AW-1:0]  cen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      rd_vld_r    <= 1'b0;
      shift_cnt_r <= '0;
      eval_r      <= 1'b0;
    end else if (cmd.start) begin
      rd_ptr_r    <= '0;
      rd_vld_r    <= 1'b0;
      shift_cnt_r <= '0;
      eval_r      <= 1'b0;
    end else begin
      rd_vld_r <= rd_issue;
      if (rd_issue) rd_ptr_r <= rd_ptr_r + BIN_CW'(1);
      eval_r <= rd_vld_r && (shift_cnt_r >= BIN_CW'(WIN_LEN - 1));
      if (rd_vld_r) shift_cnt_r <= shift_cnt_r + BIN_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      for (int i = 0; i < WIN_LEN - 1; i++) win_r[i] <= win_r[i+1];
      win_r[WIN_LEN-1] <= rd_q_r;
      cen_r <= BIN_AW'(shift_cnt_r - BIN_CW'(WINDOW_HALF));
    end
  end

  // local maximum test on the center of the window
  logic [COUNT_W-1:0] cen_v;
  logic               is_max, nb_equal, act;

  assign cen_v = win_r[WINDOW_HALF];

  always_comb begin
    is_max   = 1'b1;
    nb_equal = 1'b0;
    for (int j = 0; j < WIN_LEN; j++) begin
      if (j != WINDOW_HALF) begin
        if (win_r[j] > cen_v) begin
          is_max = 1'b0;
        end else if (win_r[j] == cen_v) begin
          if (j == WINDOW_HALF - 1 || j == WINDOW_HALF + 1) nb_equal = 1'b1;
          else is_max = 1'b0;
        end
      end
    end
  end

  assign act = eval_r && !skip_r;

  // a two-bin plateau skips the following position
  always_ff @(posedge clk) begin
    if (!rst_n) skip_r <= 1'b0;
    else if (cmd.start) skip_r <= 1'b0;
    else if (eval_r) skip_r <= act && is_max && nb_equal;
  end

  logic                a_vld_r;
  logic [BIN_AW-1:0]   a_pos_r;
  logic [COUNT_W-1:0]  a_v_r;
  logic [SCALED_W-1:0] a_scaled_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else a_vld_r <= act && is_max;
  end

  always_ff @(posedge clk) begin
    a_pos_r    <= cen_r;
    a_v_r      <= cen_v;
    a_scaled_r <= SCALED_W'(cen_v) * SCALED_W'(PERMILLE_SCALE);
  end

  // height thresholds and peak list
  logic [PK_CW-1:0]   cnt_r;
  logic               keep, over_major, over_minor, early_ok;
  logic [COUNT_W-1:0] h0_r, h1_r;
  logic [BIN_AW+COUNT_W-1:0] pk_mem [MAX_PEAKS];
  logic [BIN_AW+COUNT_W-1:0] pk_q_r;

  assign over_major = THR_W'(a_scaled_r) > maj_thr_r;
  assign over_minor = THR_W'(a_scaled_r) > min_thr_r;
  assign early_ok   = 32'(cnt_r) < 32'(early_r);
  assign keep = a_vld_r && (cnt_r < PK_CW'(MAX_PEAKS))
             && (over_major || (over_minor && early_ok));

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (cmd.start) cnt_r <= '0;
    else if (keep) cnt_r <= cnt_r + PK_CW'(1);
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      if (cnt_r == PK_CW'(0)) h0_r <= a_v_r;
      if (cnt_r == PK_CW'(1)) h1_r <= a_v_r;
    end
  end

  logic [PK_AW-1:0] out_idx_r;

  always_ff @(posedge clk) begin
    if (keep) pk_mem[cnt_r[PK_AW-1:0]] <= {a_pos_r, a_v_r};
    if (cmd.emit_rd) pk_q_r <= pk_mem[out_idx_r];
  end

  // first-peak check
  logic [REJ_W-1:0]   p0_r, p1_r;
  logic               drop;
  logic [TOTAL_W-1:0] tot_r;

  always_ff @(posedge clk) begin
    p0_r <= REJ_W'(h0_r) * REJ_W'(PERCENT_SCALE);
    p1_r <= REJ_W'(reject_r) * REJ_W'(h1_r);
  end

  assign drop = (cnt_r >= PK_CW'(2)) && (p0_r < p1_r);

  always_ff @(posedge clk) begin
    if (cmd.drop_eval) begin
      out_idx_r <= drop ? PK_AW'(1) : '0;
      tot_r     <= TOTAL_W'(cnt_r - (drop ? PK_CW'(1) : PK_CW'(0)));
    end else if (cmd.emit_wr) begin
      out_idx_r <= out_idx_r + PK_AW'(1);
    end
  end

  // output register
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      none_kept, idx_last;

  assign none_kept = (cnt_r == '0);
  assign idx_last  = (PK_CW'(out_idx_r) + PK_CW'(1) == cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit_wr) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_wr) begin
      if (none_kept) begin
        out_data_r.peak_bin    <= '0;
        out_data_r.peak_height <= '0;
        out_data_r.peak_total  <= '0;
        out_data_r.peak_valid  <= 1'b0;
        out_data_r.last_peak   <= 1'b1;
      end else begin
        out_data_r.peak_bin    <= BIN_W'(pk_q_r[BIN_AW+COUNT_W-1:COUNT_W]);
        out_data_r.peak_height <= pk_q_r[COUNT_W-1:0];
        out_data_r.peak_total  <= tot_r;
        out_data_r.peak_valid  <= 1'b1;
        out_data_r.last_peak   <= idx_last;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign stat.scan_done = (rd_ptr_r == n_r) && !rd_issue && !rd_vld_r && !eval_r && !a_vld_r;
  assign stat.emit_last = none_kept || idx_last;
  assign stat.out_free  = !out_valid_r || !out_stall;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= PK_CW'(MAX_PEAKS))
    else $error("peak count above list depth");

  a_wr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wr_idx_r <= BIN_CW'(MAX_BINS))
    else $error("bin index beyond store depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.emit_wr)
    else $error("output register overwritten while stalled");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!rd_vld_r && !eval_r && !a_vld_r))
    else $error("bin loaded while the search runs");

  a_keep_window: assert property (@(posedge clk) disable iff (!rst_n)
    keep |-> $past(eval_r))
    else $error("peak kept without an evaluated window");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import hpf_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400_000;
  localparam int unsigned RAND_ITEMS    = 110;
  localparam int unsigned PHASE_ITEMS   = 22;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned HOLD_PHASE    = 2;
  localparam int unsigned COMB_PEAKS    = 66;

  // no register sits at this index
  localparam logic [CFG_IW-1:0] REG_UNMAPPED = 3'd7;

  typedef enum int unsigned {SHAPE_PEAKS, SHAPE_TIES, SHAPE_NOISE, SHAPE_COMB} shape_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_we    = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  histogram_peak_finder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // register copies as the block should hold them
  logic [ENT_W-1:0]   sh_total  = RST_TOTAL_ENTRIES;
  logic [PM_W-1:0]    sh_major  = RST_MAJOR_PERMILLE;
  logic [PM_W-1:0]    sh_minor  = RST_MINOR_PERMILLE;
  logic [LIM_W-1:0]   sh_early  = RST_EARLY_LIMIT;
  logic [PCT_W-1:0]   sh_reject = RST_REJECT_PERCENT;

  logic [COUNT_W-1:0] hist_bins [MAX_BINS];
  int unsigned        hist_len = 0;
  out_item_t          peak_expect[$];

  in_item_t           bin_feed[$];
  logic [COUNT_W-1:0] draft[$];
  int unsigned        beats_queued = 0;
  int unsigned        beats_taken  = 0;
  int unsigned        amp          = 4000;

  bit                 in_took      = 1'b0;
  bit                 idle_on      = 1'b1;
  int unsigned        in_gap       = 0;
  int unsigned        stall_gap    = 0;
  int unsigned        hold_left    = 0;
  int unsigned        cycle_cnt    = 0;
  int unsigned        mismatch_cnt = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic bit over_share(logic [COUNT_W-1:0] c, logic [PM_W-1:0] pm);
    return 64'(c) * 64'd1000 > 64'(pm) * 64'(sh_total);
  endfunction

  // runs the peak search over the bins of the finished histogram
  function automatic void predict_peaks();
    int unsigned        pos;
    logic [COUNT_W-1:0] v;
    logic [COUNT_W-1:0] w;
    bit                 is_max;
    bit                 nb_eq;
    int unsigned        kept[$];
    out_item_t          r;
    pos = WINDOW_HALF;
    while (pos + WINDOW_HALF < hist_len) begin
      v = hist_bins[pos];
      is_max = 1'b1;
      nb_eq = 1'b0;
      for (int unsigned j = pos - WINDOW_HALF; j <= pos + WINDOW_HALF; j++) begin
        if (j != pos) begin
          w = hist_bins[j];
          if (w > v) begin
            is_max = 1'b0;
          end else if (w == v) begin
            if (j + 1 == pos || j == pos + 1) nb_eq = 1'b1;
            else is_max = 1'b0;
          end
        end
      end
      if (is_max && kept.size() < MAX_PEAKS) begin
        if (over_share(v, sh_major) ||
            (over_share(v, sh_minor) && kept.size() < sh_early)) begin
          kept = {kept, pos};
        end
      end
      // equal neighbor: step over it so a flat top counts once
      pos += (is_max && nb_eq) ? 2 : 1;
    end
    if (kept.size() >= 2) begin
      if (64'(hist_bins[kept[0]]) * 64'd100 < 64'(sh_reject) * 64'(hist_bins[kept[1]])) begin
        void'(kept.pop_front());
      end
    end
    if (kept.size() == 0) begin
      r = '0;
      r.last_peak = 1'b1;
      peak_expect = {peak_expect, r};
    end
    for (int k = 0; k < kept.size(); k++) begin
      r.peak_bin    = BIN_W'(kept[k]);
      r.peak_height = hist_bins[kept[k]];
      r.peak_total  = TOTAL_W'(kept.size());
      r.peak_valid  = 1'b1;
      r.last_peak   = (k == kept.size() - 1);
      peak_expect = {peak_expect, r};
    end
  endfunction

  function automatic void absorb_bin(in_item_t b);
    if (hist_len < MAX_BINS) begin
      hist_bins[hist_len] = b.bin_count;
      hist_len++;
    end
    if (b.last_bin) begin
      predict_peaks();
      hist_len = 0;
    end
  endfunction

  function automatic void feed_draft();
    in_item_t beat;
    foreach (draft[i]) begin
      beat.bin_count = draft[i];
      beat.last_bin  = (i == draft.size() - 1);
      bin_feed = {bin_feed, beat};
      beats_queued++;
    end
    draft.delete();
  endfunction

  function automatic void queue_histogram(int unsigned len, shape_t shape);
    int unsigned c;
    int unsigned h;
    int unsigned v;
    for (int unsigned i = 0; i < len; i++) begin
      case (shape)
        SHAPE_TIES:  draft = {draft, COUNT_W'($urandom_range(0, 3))};
        SHAPE_NOISE: draft = {draft, COUNT_W'($urandom())};
        SHAPE_COMB:  draft = {draft, (i % 4 == 3) ? COUNT_W'($urandom_range(1, amp))
                                                  : COUNT_W'(0)};
        default:     draft = {draft, COUNT_W'($urandom_range(0, amp / 16))};
      endcase
    end
    if (shape == SHAPE_PEAKS) begin
      repeat ($urandom_range(1, len / 6 + 1)) begin
        c = $urandom_range(0, len - 1);
        h = $urandom_range(amp / 4, amp);
        for (int unsigned d = 0; d <= 3; d++) begin
          v = h >> d;
          if (c + d < len && draft[c + d] < v) draft[c + d] = COUNT_W'(v);
          if (c >= d && draft[c - d] < v) draft[c - d] = COUNT_W'(v);
        end
        // flat top over two bins
        if ($urandom_range(0, 2) == 0 && c + 1 < len) draft[c + 1] = COUNT_W'(h);
      end
    end
    feed_draft();
  endfunction

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TOTAL_ENTRIES:  sh_total  = val[ENT_W-1:0];
      REG_MAJOR_PERMILLE: sh_major  = val[PM_W-1:0];
      REG_MINOR_PERMILLE: sh_minor  = val[PM_W-1:0];
      REG_EARLY_LIMIT:    sh_early  = val[LIM_W-1:0];
      REG_REJECT_PERCENT: sh_reject = val[PCT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [CFG_DW-1:0] total, major, minor, early, reject);
    write_reg(REG_TOTAL_ENTRIES, total);
    write_reg(REG_MAJOR_PERMILLE, major);
    write_reg(REG_MINOR_PERMILLE, minor);
    write_reg(REG_EARLY_LIMIT, early);
    write_reg(REG_REJECT_PERCENT, reject);
  endtask

  task automatic drain();
    while (beats_taken != beats_queued || peak_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v, got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      mismatch_cnt++;
    end
  endtask

  // bin beat driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // beat still stalled, hold it
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap--;
    end else if (bin_feed.size() > 0) begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        in_gap = $urandom_range(0, 3);
      end else begin
        in_valid <= 1'b1;
        in_data  <= bin_feed.pop_front();
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_gap > 0) begin
      out_stall <= 1'b1;
      stall_gap--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_gap = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: feeds taken bins to the predictor and checks result beats
  always @(posedge clk) begin
    out_item_t want;
    in_took = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      in_took = 1'b1;
      beats_taken++;
      absorb_bin(in_data);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (peak_expect.size() == 0) begin
        $error("result beat with none pending: peak_bin %0h", out_data.peak_bin);
        mismatch_cnt++;
      end else begin
        want = peak_expect.pop_front();
        check_field("peak_bin", 32'(want.peak_bin), 32'(out_data.peak_bin));
        check_field("peak_height", 32'(want.peak_height), 32'(out_data.peak_height));
        check_field("peak_total", 32'(want.peak_total), 32'(out_data.peak_total));
        check_field("peak_valid", 32'(want.peak_valid), 32'(out_data.peak_valid));
        check_field("last_peak", 32'(want.last_peak), 32'(out_data.last_peak));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned len;
    int unsigned rand_items;
    int unsigned chunk;
    int unsigned major;
    int unsigned pick;
    shape_t      shape;
    phase = 0;
    rand_items = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset thresholds are zero, so any nonzero local maximum is kept
    draft = '{0, 0, 0, 24'hFFFFFF, 0, 0, 0};
    feed_draft();
    // too short to search anything
    draft = '{5, 9, 1};
    feed_draft();
    // two-bin flat top gives one peak at its lower bin
    draft = '{1, 2, 3, 8, 8, 3, 2, 1, 0};
    feed_draft();
    // small first peak dropped against the second
    draft = '{0, 0, 0, 1, 0, 0, 0, 100, 0, 0, 0};
    feed_draft();
    drain();

    // enough maxima to fill the peak list
    amp = 24'hFFFFFF;
    queue_histogram(4 * COMB_PEAKS + 3, SHAPE_COMB);
    drain();

    while (rand_items < RAND_ITEMS) begin
      idle_on = (rand_items + PHASE_ITEMS < RAND_ITEMS);
      case (phase)
        0: begin
          set_regs('0, '0, '0, '0, '0);
          write_reg(REG_UNMAPPED, $urandom());
        end
        1: set_regs('1, '1, '1, '1, '1);
        2: set_regs('1, '0, 1000, MAX_PEAKS, 100);
        default: begin
          case ($urandom_range(0, 2))
            0:       amp = 15;
            1:       amp = 4000;
            default: amp = 24'hFFFFFF;
          endcase
          major = $urandom_range(1, 40);
          set_regs($urandom_range(0, amp * 100), major, $urandom_range(0, major),
                   ($urandom_range(0, 3) == 0) ? MAX_PEAKS : $urandom_range(0, 6),
                   $urandom_range(0, 100));
        end
      endcase
      chunk = 0;
      while (chunk < PHASE_ITEMS && rand_items < RAND_ITEMS) begin
        pick = $urandom_range(0, 19);
        if (phase == HOLD_PHASE) len = $urandom_range(4, 12);
        else if (pick < 14) len = $urandom_range(1, 16);
        else len = $urandom_range(17, 30);
        pick = $urandom_range(0, 9);
        if (pick < 6) shape = SHAPE_PEAKS;
        else if (pick < 8) shape = SHAPE_TIES;
        else if (pick < 9) shape = SHAPE_NOISE;
        else shape = SHAPE_COMB;
        queue_histogram(len, shape);
        chunk += len;
        rand_items += len;
      end
      // long receiver hold-off while several histograms wait at the input
      if (phase == HOLD_PHASE) hold_left = HOLD_CYCLES;
      drain();
      phase++;
    end

    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
